@@ sv/bvsg_pkg.sv @@
// shared types, constants and the state-of-charge function for the battery gauge
// no dependencies; imported by every module of the gauge
`default_nettype none

package bvsg_pkg;

    // field and register widths
    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int CURRENT_W   = 16;
    localparam int VOLT_W      = 16;
    localparam int PCT_W       = 7;
    localparam int GAIN_W      = 10;
    localparam int VREF_W      = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    // box-car stages
    localparam int SUM_W = 16;
    localparam int CNT_W = 4;
    localparam int AVG_W = 12;
    localparam logic [CNT_W-1:0] STAGE_LAST = 4'd15;

    // scaling chain: shared 12x12 multiplier, then divide by 100 through a reciprocal
    localparam int MUL_W     = 12;
    localparam int PROD_W    = 24;
    localparam int RCP_W     = 23;
    localparam int QPROD_W   = PROD_W + RCP_W;
    localparam int RCP_SHIFT = 29;
    // ceil(2^29 / 100); exact for dividends below 2^29 / 88, well above 4095 * 1023
    localparam logic [RCP_W-1:0] RCP_100 = 23'd5368710;

    // reset values of the configuration registers
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd593;
    localparam logic [VREF_W-1:0] VREF_RESET = 12'd3330;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF = 1'd1;

    // state-of-charge band edges in millivolts
    localparam logic [VOLT_W-1:0] SOC_V_FULL = 16'd13049;
    localparam logic [VOLT_W-1:0] SOC_V_B75  = 16'd12550;
    localparam logic [VOLT_W-1:0] SOC_V_B50  = 16'd12300;
    localparam logic [VOLT_W-1:0] SOC_V_B25  = 16'd12000;
    localparam logic [VOLT_W-1:0] SOC_V_B0   = 16'd11760;

    // reciprocals scaled by 2^16: 1/20, 1/10, 1/12 and 5/48
    localparam logic [12:0] RCP_B75 = 13'd3277;
    localparam logic [12:0] RCP_B50 = 13'd6554;
    localparam logic [12:0] RCP_B25 = 13'd5462;
    localparam logic [12:0] RCP_B0  = 13'd6827;

    // datapath command and status groups
    typedef struct packed {
        logic capture;
        logic accumulate;
        logic mul_a;
        logic mul_b;
        logic divide;
        logic soc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic will_update;
    } t_dp_sts;

    // piecewise-linear state of charge; band offsets stay below 500 so the
    // reciprocal products are exact after the shift
    function automatic logic [PCT_W-1:0] soc_percent(input logic [VOLT_W-1:0] v);
        logic [8:0]           x;
        logic [21:0]          p;
        logic [PCT_W-1:0]     pct;
        x   = '0;
        p   = '0;
        pct = '0;
        if (v > SOC_V_FULL) begin
            pct = 7'd100;
        end else if (v >= SOC_V_B75) begin
            x   = 9'(v - SOC_V_B75);
            p   = 22'(x) * 22'(RCP_B75);
            pct = 7'd75 + 7'(p[20:16]);
        end else if (v >= SOC_V_B50) begin
            x   = 9'(v - SOC_V_B50);
            p   = 22'(x) * 22'(RCP_B50);
            pct = 7'd50 + 7'(p[20:16]);
        end else if (v >= SOC_V_B25) begin
            x   = 9'(v - SOC_V_B25);
            p   = 22'(x) * 22'(RCP_B25);
            pct = 7'd25 + 7'(p[20:16]);
        end else if (v >= SOC_V_B0) begin
            x   = 9'(v - SOC_V_B0);
            p   = 22'(x) * 22'(RCP_B0);
            pct = 7'(p[20:16]);
        end
        return pct;
    endfunction

endpackage

`default_nettype wire

@@ sv/bvsg_cfg_regs.sv @@
// configuration registers of the battery gauge: divider gain and adc reference
// depends on bvsg_pkg
`default_nettype none

module bvsg_cfg_regs
    import bvsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [GAIN_W-1:0]          o_gain_centi,
    output logic [VREF_W-1:0]          o_vref_mv
);

    logic [GAIN_W-1:0] r_gain_centi;
    logic [VREF_W-1:0] r_vref_mv;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write, keeping only each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_centi <= GAIN_RESET;
            r_vref_mv    <= VREF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN: begin
                    r_gain_centi <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_VREF: begin
                    r_vref_mv <= i_cfg_data[VREF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_gain_centi = r_gain_centi;
    assign o_vref_mv    = r_vref_mv;

endmodule

`default_nettype wire

@@ sv/bvsg_ctrl.sv @@
// sequencer of the battery gauge: input and output handshakes, scaling steps
// depends on bvsg_pkg
`default_nettype none

module bvsg_ctrl
    import bvsg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_sts  i_sts,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_SOC,
        S_FIN
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_dp_cmd           w_cmd;

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                w_cmd.accumulate = 1'b1;
                n_state          = i_sts.will_update ? S_MUL_A : S_FIN;
            end
            S_MUL_A: begin
                w_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                w_cmd.mul_b = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                w_cmd.divide = 1'b1;
                n_state      = S_SOC;
            end
            S_SOC: begin
                w_cmd.soc = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

@@ sv/bvsg_dp.sv @@
// datapath of the battery gauge: box-car stages, shared multiplier,
// reciprocal divide by 100, state of charge and output register; depends on bvsg_pkg
`default_nettype none

module bvsg_dp
    import bvsg_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [GAIN_W-1:0]    i_gain_centi,
    input  wire logic [VREF_W-1:0]    i_vref_mv,
    input  wire logic [SAMPLE_W-1:0]  i_adc_sample,
    input  wire logic signed [CURRENT_W-1:0] i_current_ma,
    output logic [VOLT_W-1:0]         o_voltage_mv,
    output logic [PCT_W-1:0]          o_percent,
    output logic                      o_charging,
    output logic                      o_updated
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // input capture
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_charging;

    // box-car stages
    logic [SUM_W-1:0] r_s1_sum;
    logic [CNT_W-1:0] r_s1_cnt;
    logic [SUM_W-1:0] r_s2_sum;
    logic [CNT_W-1:0] r_s2_cnt;
    logic [AVG_W-1:0] r_avg2;
    logic             r_updated;

    // scaling chain
    logic [PROD_W-1:0] r_prod;
    logic [VOLT_W-1:0] r_filt;
    logic [PCT_W-1:0]  r_pct;

    // output register
    logic [VOLT_W-1:0] r_o_voltage;
    logic [PCT_W-1:0]  r_o_pct;
    logic              r_o_charging;
    logic              r_o_updated;

    logic [AVG_W-1:0]   w_avg1;
    logic [MUL_W-1:0]   w_mul_a;
    logic [MUL_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [QPROD_W-1:0] w_qprod;
    logic [VOLT_W-1:0]  w_quot;

    assign w_avg1 = AVG_W'(r_s1_sum >> CNT_W);

    // shared multiplier: vref times average, then scaled value times gain
    always_comb begin
        if (i_cmd.mul_b) begin
            w_mul_a = MUL_W'(r_prod >> SAMPLE_BITS);
            w_mul_b = MUL_W'(i_gain_centi);
        end else begin
            w_mul_a = i_vref_mv;
            w_mul_b = r_avg2;
        end
    end
    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // divide by 100 as a multiply by the scaled reciprocal
    assign w_qprod = QPROD_W'(r_prod) * QPROD_W'(RCP_100);
    assign w_quot  = w_qprod[RCP_SHIFT +: VOLT_W];

    assign o_sts.will_update = (r_s1_cnt == STAGE_LAST) && (r_s2_cnt == STAGE_LAST);

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample   <= i_adc_sample & SAMPLE_MASK;
            r_charging <= !i_current_ma[CURRENT_W-1] && (i_current_ma != '0);
        end
    end

    // box-car stages, held voltage and state of charge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_sum  <= '0;
            r_s1_cnt  <= '0;
            r_s2_sum  <= '0;
            r_s2_cnt  <= '0;
            r_updated <= 1'b0;
            r_filt    <= '0;
            r_pct     <= '0;
        end else begin
            if (i_cmd.accumulate) begin
                r_updated <= 1'b0;
                if (r_s1_cnt == STAGE_LAST) begin
                    r_s1_cnt <= '0;
                    r_s1_sum <= SUM_W'(r_sample);
                    if (r_s2_cnt == STAGE_LAST) begin
                        r_updated <= 1'b1;
                        r_s2_cnt  <= '0;
                        r_s2_sum  <= SUM_W'(w_avg1);
                    end else begin
                        r_s2_sum <= r_s2_sum + SUM_W'(w_avg1);
                        r_s2_cnt <= r_s2_cnt + 1'b1;
                    end
                end else begin
                    r_s1_sum <= r_s1_sum + SUM_W'(r_sample);
                    r_s1_cnt <= r_s1_cnt + 1'b1;
                end
            end
            if (i_cmd.divide) begin
                r_filt <= w_quot;
            end
            if (i_cmd.soc) begin
                r_pct <= soc_percent(r_filt);
            end
        end
    end

    // stage-two average latched before the stage restarts
    always_ff @(posedge i_clk) begin
        if (i_cmd.accumulate) begin
            r_avg2 <= AVG_W'(r_s2_sum >> CNT_W);
        end
    end

    // product register of the shared multiplier
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_voltage  <= r_filt;
            r_o_pct      <= r_pct;
            r_o_charging <= r_charging;
            r_o_updated  <= r_updated;
        end
    end

    assign o_voltage_mv = r_o_voltage;
    assign o_percent    = r_o_pct;
    assign o_charging   = r_o_charging;
    assign o_updated    = r_o_updated;

endmodule

`default_nettype wire

@@ sv/battery_voltage_soc_gauge_core.sv @@
// Battery voltage gauge. Each transfer carries one ADC sample and a signed current and
// returns one result: the held battery voltage in millivolts, a 0..100 state of charge and
// a charging flag. Samples pass two cascaded 16-entry box-car averagers (the first block of
// each after reset holds 15); when stage two completes, its average is scaled by the
// reference and divider gain and o_updated is set. An item that does not complete stage two
// goes through capture, accumulate and output load; one that does goes through capture,
// accumulate, two passes through the shared 12x12 multiplier, one reciprocal multiply for
// the divide by 100, one state-of-charge step and the output load. The output load waits
// while the previous result is still stalled. After reset the first update comes on item
// 256, then every 256.
// A new input transfer is taken while a finished result waits for the output side.
// depends on bvsg_pkg, bvsg_cfg_regs, bvsg_ctrl and bvsg_dp
`default_nettype none

module battery_voltage_soc_gauge_core
    import bvsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [SAMPLE_W-1:0]   i_adc_sample,
    input  wire logic signed [CURRENT_W-1:0] i_current_ma,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [VOLT_W-1:0]          o_voltage_mv,
    output logic [PCT_W-1:0]           o_percent,
    output logic                       o_charging,
    output logic                       o_updated,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GAIN_W-1:0] w_gain_centi;
    logic [VREF_W-1:0] w_vref_mv;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;

    // configuration registers
    bvsg_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_gain_centi (w_gain_centi),
        .o_vref_mv    (w_vref_mv)
    );

    // sequencer
    bvsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    bvsg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_gain_centi (w_gain_centi),
        .i_vref_mv    (w_vref_mv),
        .i_adc_sample (i_adc_sample),
        .i_current_ma (i_current_ma),
        .o_voltage_mv (o_voltage_mv),
        .o_percent    (o_percent),
        .o_charging   (o_charging),
        .o_updated    (o_updated)
    );

    // the output register is only reloaded once the previous result has left
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a pending transfer");

    // a stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_voltage_mv) && $stable(o_percent) &&
             $stable(o_charging) && $stable(o_updated)))
        else $error("stalled result changed");

    // state of charge stays within 0..100
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_percent <= 7'd100))
        else $error("state of charge above 100");

endmodule

`default_nettype wire
